// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
// Package with the types and constants of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 24;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CUR_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int CELL_W     = 16;

  localparam logic       OP_PUT         = 1'b0;
  localparam logic       OP_READ        = 1'b1;
  localparam logic [8:0] CODE_NEWLINE   = 9'd10;
  localparam logic [8:0] CODE_BACKSPACE = 9'h100;
  localparam logic [7:0] CODE_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET     = 8'h07;

  typedef struct packed {
    logic        opcode;
    logic [8:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
    logic        scrolled;
  } tcw_out_t;

  // Commands from the sequencer to the cursor unit.
  typedef struct packed {
    logic       put;
    logic       scroll;
    logic [8:0] code;
  } tcw_cur_cmd_t;

  // Cursor unit status.
  typedef struct packed {
    logic [CUR_W-1:0] pos;
    logic             overflow;
  } tcw_cur_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_WIPE,
    S_SPACE,
    S_DONE
  } tcw_state_t;

endpackage

// File: hw/rtl/tcw_cursor.sv
// Cursor unit: cell index and column of the cursor, moved by puts and scrolls.
`timescale 1ns / 1ps
module tcw_cursor
  import tcw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tcw_cur_cmd_t  cmd,
  output tcw_cur_stat_t stat
);

  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    if (cmd.scroll) begin
      // Column is already zero when the cursor runs past the last row.
      cursor_nxt = cursor_r - CUR_W'(COLUMNS);
    end else if (cmd.put) begin
      priority if (cmd.code == CODE_NEWLINE) begin
        cursor_nxt = cursor_r + CUR_W'(COLUMNS) - CUR_W'(col_r);
        col_nxt    = '0;
      end else if (cmd.code == CODE_BACKSPACE) begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - CUR_W'(1);
          col_nxt    = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - COL_W'(1);
        end
      end else begin
        cursor_nxt = cursor_r + CUR_W'(1);
        col_nxt    = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

  assign stat.pos      = cursor_r;
  assign stat.overflow = (cursor_r >= CUR_W'(CELL_COUNT));

endmodule

// File: hw/rtl/text_console_writer.sv
// Top level of the text console writer: screen memory, sequencer and result register.
`timescale 1ns / 1ps
// The screen lives in one 1920 x 16-bit memory with one write and one registered read
// port. After reset the block sweeps the memory to zero and takes no item meanwhile
// (attribute writes are taken at any time). A read or a put without scroll passes
// through the transfer step (memory read or character write), the execute step, which
// for a put writes the space under the cursor, and the done step, which loads the
// result register once the output register is free. A put that moves the cursor past
// the last row instead spends its execute step starting the scroll, copies rows 1 to
// 23 up through the memory, one cell per cycle, clears the last row, writes the space
// under the cursor and loads the result register. A new item is taken as soon as the
// previous result sits in the output register.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tcw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tcw_out_t out_data,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);

  tcw_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]        attr_r;
  logic              op_r, op_nxt;
  logic              inrange_r, inrange_nxt;
  logic              scroll_r, scroll_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_data_r, out_data_nxt;

  logic [CELL_W-1:0] screen_r [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  tcw_cur_cmd_t  cur_cmd;
  tcw_cur_stat_t cur_stat;
  logic          in_xfer;
  logic          out_free;

  tcw_cursor u_cursor (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cur_cmd),
    .stat (cur_stat)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    inrange_nxt   = inrange_r;
    scroll_nxt    = scroll_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    cur_cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = cnt_r;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt      = in_data.opcode;
          inrange_nxt = (int'(in_data.cell_index) < CELL_COUNT);
          scroll_nxt  = 1'b0;
          state_nxt   = S_EXEC;
          if (in_data.opcode == OP_READ) begin
            rd_en   = inrange_nxt;
            rd_addr = in_data.cell_index[ADDR_W-1:0];
          end else begin
            cur_cmd.put  = 1'b1;
            cur_cmd.code = in_data.char_code;
            if (in_data.char_code != CODE_NEWLINE && in_data.char_code != CODE_BACKSPACE) begin
              mem_we  = 1'b1;
              wr_addr = cur_stat.pos[ADDR_W-1:0];
              wr_data = {attr_r, in_data.char_code[7:0]};
            end
          end
        end
      end
      S_EXEC: begin
        if (op_r == OP_READ) begin
          state_nxt = S_DONE;
        end else if (cur_stat.overflow) begin
          cur_cmd.scroll = 1'b1;
          scroll_nxt     = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_COPY;
        end else begin
          mem_we    = 1'b1;
          wr_addr   = cur_stat.pos[ADDR_W-1:0];
          wr_data   = {attr_r, CODE_SPACE};
          state_nxt = S_DONE;
        end
      end
      S_COPY: begin
        // Read a row below, write it back one row up in the next cycle.
        rd_en   = (cnt_r != COPY_END);
        rd_addr = cnt_r + ADDR_W'(COLUMNS);
        mem_we  = (cnt_r != '0);
        wr_addr = cnt_r - ADDR_W'(1);
        wr_data = rd_data_r;
        if (cnt_r == COPY_END) begin
          state_nxt = S_WIPE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_WIPE: begin
        mem_we  = 1'b1;
        wr_addr = cnt_r;
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_SPACE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_SPACE: begin
        mem_we    = 1'b1;
        wr_addr   = cur_stat.pos[ADDR_W-1:0];
        wr_data   = {attr_r, CODE_SPACE};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_position = 11'(cur_stat.pos);
          out_data_nxt.cell_value      = (op_r == OP_READ && inrange_r) ? rd_data_r : '0;
          out_data_nxt.scrolled        = scroll_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      attr_r      <= ATTR_RESET;
      op_r        <= OP_PUT;
      inrange_r   <= 1'b0;
      scroll_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      inrange_r   <= inrange_nxt;
      scroll_r    <= scroll_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= screen_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_cursor_in_range, state_r == S_IDLE, !cur_stat.overflow,
               "cursor beyond screen while idle")
  `ASSERT_IMPL(a_overflow_only_exec, cur_stat.overflow, state_r == S_EXEC,
               "cursor overflow outside the execute step")
  `ASSERT_NEXT(a_scroll_starts_copy, state_r == S_EXEC && op_r == OP_PUT && cur_stat.overflow,
               state_r == S_COPY && scroll_r, "overflowing put did not start the row copy")
  `ASSERT_IMPL(a_no_write_idle, state_r == S_IDLE || state_r == S_DONE, !mem_we || in_xfer,
               "screen written with no item in progress")

endmodule

// File: sim/tb.sv
// Self-checking testbench for the text console writer with a per-item screen predictor.
`timescale 1ns / 1ps
module tb;
  import tcw_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_REPORTS   = 10;
  // Worst case: every item scrolls and sees both random stalls, input gap and receiver gap.
  localparam int unsigned LIMIT_CYCLES = 10_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  tcw_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tcw_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // Predicted screen contents, cursor and attribute.
  logic [15:0] screen_model [CELL_COUNT];
  int          cursor_model = 0;
  logic [7:0]  attr_model = ATTR_RESET;
  tcw_out_t    pending_results [$];
  tcw_out_t    oldest_result;

  int failures = 0;
  int items_sent = 0;
  int put_count = 0;
  int read_count = 0;
  int scroll_count = 0;
  int newline_count = 0;
  int backspace_count = 0;
  int attr_writes = 0;
  bit idling = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int ready_gap = 0;
  int unsigned cycle_count = 0;

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = '0;
  end

  // Applies one accepted item to the predicted screen and returns the expected result.
  function automatic tcw_out_t apply_to_screen(tcw_in_t item);
    tcw_out_t res;
    int i;
    res = '0;
    if (cursor_model >= CELL_COUNT) cursor_model = 0;
    if (item.opcode == OP_READ) begin
      read_count++;
      if (item.cell_index < CELL_COUNT) res.cell_value = screen_model[item.cell_index];
    end else begin
      put_count++;
      if (item.char_code == CODE_NEWLINE) begin
        newline_count++;
        cursor_model += COLUMNS - cursor_model % COLUMNS;
      end else if (item.char_code == CODE_BACKSPACE) begin
        backspace_count++;
        if (cursor_model > 0) cursor_model--;
      end else begin
        screen_model[cursor_model] = {attr_model, item.char_code[7:0]};
        cursor_model++;
      end
      if (cursor_model / COLUMNS >= ROWS) begin
        for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        cursor_model -= COLUMNS;
        for (i = cursor_model; i < CELL_COUNT; i++) screen_model[i] = '0;
        res.scrolled = 1'b1;
        scroll_count++;
      end
      screen_model[cursor_model] = {attr_model, CODE_SPACE};
    end
    res.cursor_position = cursor_model[10:0];
    return res;
  endfunction

  task automatic report_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) pending_results.push_back(apply_to_screen(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result cursor=%0d cell=%h scrolled=%0d",
                                   out_data.cursor_position, out_data.cell_value,
                                   out_data.scrolled));
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_data.cursor_position !== oldest_result.cursor_position ||
              out_data.cell_value !== oldest_result.cell_value ||
              out_data.scrolled !== oldest_result.scrolled) begin
            report_failure($sformatf(
              "expected cursor=%0d cell=%h scrolled=%0d, got cursor=%0d cell=%h scrolled=%0d",
              oldest_result.cursor_position, oldest_result.cell_value, oldest_result.scrolled,
              out_data.cursor_position, out_data.cell_value, out_data.scrolled));
          end
        end
      end
    end
  end

  // Result receiver: random stall bursts while idling is set, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      ready_gap = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic tcw_in_t make_item(logic op, logic [8:0] code, logic [10:0] idx);
    tcw_in_t item;
    item.opcode = op;
    item.char_code = code;
    item.cell_index = idx;
    return item;
  endfunction

  function automatic logic [8:0] random_glyph();
    if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(32, 126));
  endfunction

  // Offers one item and returns at the edge where it is transferred.
  task automatic send_item(tcw_in_t item);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic put_code(logic [8:0] code);
    send_item(make_item(OP_PUT, code, 11'($urandom)));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_item(make_item(OP_READ, 9'($urandom), idx));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_attribute(logic [7:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    attr_model = value;
    attr_writes++;
  endtask

  task automatic test_basic_edits();
    put_code(CODE_BACKSPACE);   // backspace with the cursor already at zero
    read_cell(11'd0);
    put_code(9'h041);
    put_code(9'h000);
    put_code(9'h0ff);
    put_code(9'h1ff);           // codes above backspace keep only their low byte
    put_code(9'h101);
    put_code(CODE_NEWLINE);
    put_code(CODE_BACKSPACE);   // steps back over the start of row one
    put_code(9'h07e);
    for (int i = 0; i < 6; i++) read_cell(11'(i));
    read_cell(11'd79);
    read_cell(11'd80);
    read_cell(11'(CELL_COUNT - 1));
    read_cell(11'(CELL_COUNT));  // out of range reads return zero
    read_cell(11'h7ff);
    wait_idle();
  endtask

  task automatic test_attribute_extremes();
    set_attribute(8'h00);
    put_code(9'h05a);
    read_cell(11'(cursor_model));
    set_attribute(8'hff);
    put_code(9'h0a5);
    put_code(CODE_NEWLINE);
    read_cell(11'(cursor_model));
    wait_idle();
  endtask

  // Reaches the last row by newlines, then scrolls by wrapping and by a newline.
  task automatic test_scroll_paths();
    set_attribute(8'($urandom));
    for (int i = 0; i < ROWS; i++) put_code(CODE_NEWLINE);
    wait_idle();
    for (int i = 0; i < COLUMNS; i++) put_code(random_glyph());
    put_code(CODE_NEWLINE);
    for (int i = 0; i < 8; i++) read_cell(11'($urandom_range(CELL_COUNT - 3 * COLUMNS,
                                                             CELL_COUNT - 1)));
    wait_idle();
  endtask

  // The receiver stops for a long stretch while items keep coming, so the block backs up.
  task automatic test_output_backpressure();
    idling = 1'b0;
    hold_seq++;
    @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) read_cell(11'($urandom_range(0, CELL_COUNT - 1)));
      else put_code(random_glyph());
    end
    wait_idle();
    idling = 1'b1;
  endtask

  // Mostly lines of text ended by newlines, with backspaces, reads and raw noise between.
  task automatic run_text_phase(int count);
    int target;
    int kind;
    int len;
    int r;
    int idx;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) put_code(random_glyph());
        if ($urandom_range(0, 5) != 0) put_code(CODE_NEWLINE);
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 3)) put_code(CODE_BACKSPACE);
      end else if (kind < 95) begin
        r = $urandom_range(0, 9);
        if (r < 5) idx = (cursor_model >= 12) ? cursor_model - $urandom_range(0, 12)
                                              : $urandom_range(0, 12);
        else if (r < 8) idx = $urandom_range(0, CELL_COUNT - 1);
        else idx = $urandom_range(CELL_COUNT, 2047);
        read_cell(11'(idx));
      end else begin
        send_item(tcw_in_t'($urandom));
      end
    end
  endtask

  task automatic test_random_text();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_attribute(ATTR_RESET);
        1: set_attribute(8'hff);
        2: set_attribute(8'h00);
        default: set_attribute(8'($urandom));
      endcase
      idling = (phase < 4);
      run_text_phase(230);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_edits();
    test_attribute_extremes();
    test_scroll_paths();
    test_output_backpressure();
    test_random_text();
    $display("Covered %0d puts (%0d scrolls, %0d newlines, %0d backspaces) and %0d reads.",
             put_count, scroll_count, newline_count, backspace_count, read_count);
    $display("Attribute set %0d times; receiver held off once for %0d cycles; %0d failures.",
             attr_writes, HOLD_CYCLES, failures);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: text_console_writer.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_writer.sv
sim/tb.sv
